[sv/assert_macros.svh]
// Assertion macros for the RTL files, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define E8A_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("e8a assertion failed");

// Condition that must never be true outside reset.
`define E8A_ASSERT_NEVER(label, clk, rst_n, cond) \
    `E8A_ASSERT(label, clk, rst_n, !(cond))

`endif

[sv/e8a_pkg.sv]
// Package for the 8-bit ALU and status unit: opcodes, flag positions, word types.
package e8a_pkg;

    localparam int unsigned OP_W      = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned S_USER_W  = 7;
    localparam int unsigned M_DATA_W  = 56;
    localparam int unsigned M_USED_W  = 50;

    // Status bit positions: N V U B D I Z C
    localparam int unsigned FL_N = 7;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_C = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
        OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
        OP_BIT = 6'd8,  OP_LDA = 6'd9,  OP_LDX = 6'd10, OP_LDY = 6'd11,
        OP_STA = 6'd12, OP_STX = 6'd13, OP_STY = 6'd14,
        OP_ASL = 6'd15, OP_LSR = 6'd16, OP_ROL = 6'd17, OP_ROR = 6'd18,
        OP_INC = 6'd19,
        OP_INX = 6'd20, OP_INY = 6'd21, OP_DEX = 6'd22, OP_DEY = 6'd23,
        OP_TAX = 6'd24, OP_TAY = 6'd25, OP_TXA = 6'd26, OP_TYA = 6'd27,
        OP_TSX = 6'd28, OP_TXS = 6'd29,
        OP_CLC = 6'd30, OP_CLD = 6'd31, OP_CLI = 6'd32, OP_CLV = 6'd33,
        OP_SEC = 6'd34, OP_SED = 6'd35, OP_SEI = 6'd36,
        OP_PHA = 6'd37, OP_PHP = 6'd38, OP_PLA = 6'd39, OP_PLP = 6'd40,
        OP_BRK = 6'd41,
        OP_BPL = 6'd42, OP_BMI = 6'd43, OP_BVC = 6'd44, OP_BVS = 6'd45,
        OP_BCC = 6'd46, OP_BCS = 6'd47, OP_BNE = 6'd48, OP_BEQ = 6'd49,
        OP_NOP = 6'd50
    } t_op;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] status;
    } t_regs;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] operand;
        logic              on_acc;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              write_back;
        logic              branch_taken;
    } t_resp;

    // Update N and Z from a result byte.
    function automatic logic [BYTE_W-1:0] set_nz(input logic [BYTE_W-1:0] st,
                                                  input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] s;
        s       = st;
        s[FL_Z] = (v == '0);
        s[FL_N] = v[BYTE_W-1];
        return s;
    endfunction

endpackage

[sv/e8a_exec.sv]
// Single-pass execution logic: next register state and result word for one operation.
module e8a_exec (
    input  e8a_pkg::t_req  i_req,
    input  e8a_pkg::t_regs i_regs,
    output e8a_pkg::t_regs o_regs,
    output e8a_pkg::t_resp o_resp
);

    logic [e8a_pkg::BYTE_W-1:0] w_m;
    logic [e8a_pkg::BYTE_W-1:0] w_addend;
    logic [e8a_pkg::BYTE_W:0]   w_sum;
    logic [e8a_pkg::BYTE_W-1:0] w_cmp_reg;
    logic [e8a_pkg::BYTE_W:0]   w_diff;
    logic [e8a_pkg::BYTE_W-1:0] w_mod_in;
    logic [e8a_pkg::BYTE_W-1:0] w_mod_out;
    logic                       w_mod_c;
    logic                       w_c;
    logic [e8a_pkg::BYTE_W-1:0] w_p;
    logic [e8a_pkg::BYTE_W-1:0] w_push_p;

    assign w_m      = i_req.operand;
    assign w_p      = i_regs.status;
    assign w_c      = w_p[e8a_pkg::FL_C];
    assign w_push_p = w_p | (8'h01 << e8a_pkg::FL_B) | (8'h01 << e8a_pkg::FL_U);

    // shared adder for ADC / SBC (SBC adds the inverted operand)
    assign w_addend = (e8a_pkg::t_op'(i_req.op) == e8a_pkg::OP_SBC) ? ~w_m : w_m;
    assign w_sum    = {1'b0, i_regs.acc} + {1'b0, w_addend} + {8'd0, w_c};

    // shared comparator for CMP / CPX / CPY
    always_comb begin
        unique case (e8a_pkg::t_op'(i_req.op))
            e8a_pkg::OP_CPX: w_cmp_reg = i_regs.x;
            e8a_pkg::OP_CPY: w_cmp_reg = i_regs.y;
            default:         w_cmp_reg = i_regs.acc;
        endcase
    end
    assign w_diff = {1'b0, w_cmp_reg} - {1'b0, w_m};

    // shift / rotate / increment unit
    assign w_mod_in = i_req.on_acc ? i_regs.acc : w_m;
    always_comb begin
        w_mod_c = w_c;
        unique case (e8a_pkg::t_op'(i_req.op))
            e8a_pkg::OP_ASL: begin
                w_mod_c   = w_mod_in[7];
                w_mod_out = {w_mod_in[6:0], 1'b0};
            end
            e8a_pkg::OP_LSR: begin
                w_mod_c   = w_mod_in[0];
                w_mod_out = {1'b0, w_mod_in[7:1]};
            end
            e8a_pkg::OP_ROL: begin
                w_mod_c   = w_mod_in[7];
                w_mod_out = {w_mod_in[6:0], w_c};
            end
            e8a_pkg::OP_ROR: begin
                w_mod_c   = w_mod_in[0];
                w_mod_out = {w_c, w_mod_in[7:1]};
            end
            default: begin
                w_mod_out = w_mod_in + 8'd1;
            end
        endcase
    end

    always_comb begin
        o_regs = i_regs;
        o_resp = '0;
        unique case (e8a_pkg::t_op'(i_req.op))
            e8a_pkg::OP_ORA: begin
                o_regs.acc    = i_regs.acc | w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.acc | w_m);
            end
            e8a_pkg::OP_AND: begin
                o_regs.acc    = i_regs.acc & w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.acc & w_m);
            end
            e8a_pkg::OP_EOR: begin
                o_regs.acc    = i_regs.acc ^ w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.acc ^ w_m);
            end
            e8a_pkg::OP_ADC, e8a_pkg::OP_SBC: begin
                o_regs.acc    = w_sum[7:0];
                o_regs.status = e8a_pkg::set_nz(w_p, w_sum[7:0]);
                o_regs.status[e8a_pkg::FL_C] = w_sum[8];
                o_regs.status[e8a_pkg::FL_V] =
                    ~(i_regs.acc[7] ^ w_addend[7]) & (i_regs.acc[7] ^ w_sum[7]);
            end
            e8a_pkg::OP_CMP, e8a_pkg::OP_CPX, e8a_pkg::OP_CPY: begin
                o_regs.status[e8a_pkg::FL_Z] = (w_cmp_reg == w_m);
                o_regs.status[e8a_pkg::FL_C] = ~w_diff[8];
                o_regs.status[e8a_pkg::FL_N] = w_diff[7];
            end
            e8a_pkg::OP_BIT: begin
                o_regs.status[e8a_pkg::FL_Z] = ((i_regs.acc & w_m) == '0);
                o_regs.status[e8a_pkg::FL_N] = w_m[7];
                o_regs.status[e8a_pkg::FL_V] = w_m[6];
            end
            e8a_pkg::OP_LDA, e8a_pkg::OP_PLA: begin
                o_regs.acc    = w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, w_m);
            end
            e8a_pkg::OP_LDX: begin
                o_regs.x      = w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, w_m);
            end
            e8a_pkg::OP_LDY: begin
                o_regs.y      = w_m;
                o_regs.status = e8a_pkg::set_nz(w_p, w_m);
            end
            e8a_pkg::OP_STA, e8a_pkg::OP_PHA: begin
                o_resp.result_byte = i_regs.acc;
                o_resp.write_back  = 1'b1;
            end
            e8a_pkg::OP_STX: begin
                o_resp.result_byte = i_regs.x;
                o_resp.write_back  = 1'b1;
            end
            e8a_pkg::OP_STY: begin
                o_resp.result_byte = i_regs.y;
                o_resp.write_back  = 1'b1;
            end
            e8a_pkg::OP_ASL, e8a_pkg::OP_LSR, e8a_pkg::OP_ROL, e8a_pkg::OP_ROR,
            e8a_pkg::OP_INC: begin
                o_regs.status = e8a_pkg::set_nz(w_p, w_mod_out);
                o_regs.status[e8a_pkg::FL_C] = w_mod_c;
                if (i_req.on_acc) begin
                    o_regs.acc = w_mod_out;
                end else begin
                    o_resp.result_byte = w_mod_out;
                    o_resp.write_back  = 1'b1;
                end
            end
            e8a_pkg::OP_INX: begin
                o_regs.x      = i_regs.x + 8'd1;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.x + 8'd1);
            end
            e8a_pkg::OP_INY: begin
                o_regs.y      = i_regs.y + 8'd1;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.y + 8'd1);
            end
            e8a_pkg::OP_DEX: begin
                o_regs.x      = i_regs.x - 8'd1;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.x - 8'd1);
            end
            e8a_pkg::OP_DEY: begin
                o_regs.y      = i_regs.y - 8'd1;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.y - 8'd1);
            end
            e8a_pkg::OP_TAX: begin
                o_regs.x      = i_regs.acc;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.acc);
            end
            e8a_pkg::OP_TAY: begin
                o_regs.y      = i_regs.acc;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.acc);
            end
            e8a_pkg::OP_TXA: begin
                o_regs.acc    = i_regs.x;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.x);
            end
            e8a_pkg::OP_TYA: begin
                o_regs.acc    = i_regs.y;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.y);
            end
            e8a_pkg::OP_TSX: begin
                o_regs.x      = i_regs.sp;
                o_regs.status = e8a_pkg::set_nz(w_p, i_regs.sp);
            end
            e8a_pkg::OP_TXS: o_regs.sp = i_regs.x;     // flags untouched
            e8a_pkg::OP_CLC: o_regs.status[e8a_pkg::FL_C] = 1'b0;
            e8a_pkg::OP_CLD: o_regs.status[e8a_pkg::FL_D] = 1'b0;
            e8a_pkg::OP_CLI: o_regs.status[e8a_pkg::FL_I] = 1'b0;
            e8a_pkg::OP_CLV: o_regs.status[e8a_pkg::FL_V] = 1'b0;
            e8a_pkg::OP_SEC: o_regs.status[e8a_pkg::FL_C] = 1'b1;
            e8a_pkg::OP_SED: o_regs.status[e8a_pkg::FL_D] = 1'b1;
            e8a_pkg::OP_SEI: o_regs.status[e8a_pkg::FL_I] = 1'b1;
            e8a_pkg::OP_PHP: begin
                o_resp.result_byte = w_push_p;
                o_resp.write_back  = 1'b1;
            end
            e8a_pkg::OP_PLP: begin
                o_regs.status = w_m;
                o_regs.status[e8a_pkg::FL_B] = 1'b0;
                o_regs.status[e8a_pkg::FL_U] = 1'b1;
            end
            e8a_pkg::OP_BRK: begin
                o_resp.result_byte = w_push_p;
                o_resp.write_back  = 1'b1;
                o_regs.status[e8a_pkg::FL_I] = 1'b1;
            end
            e8a_pkg::OP_BPL: o_resp.branch_taken = ~w_p[e8a_pkg::FL_N];
            e8a_pkg::OP_BMI: o_resp.branch_taken =  w_p[e8a_pkg::FL_N];
            e8a_pkg::OP_BVC: o_resp.branch_taken = ~w_p[e8a_pkg::FL_V];
            e8a_pkg::OP_BVS: o_resp.branch_taken =  w_p[e8a_pkg::FL_V];
            e8a_pkg::OP_BCC: o_resp.branch_taken = ~w_p[e8a_pkg::FL_C];
            e8a_pkg::OP_BCS: o_resp.branch_taken =  w_p[e8a_pkg::FL_C];
            e8a_pkg::OP_BNE: o_resp.branch_taken = ~w_p[e8a_pkg::FL_Z];
            e8a_pkg::OP_BEQ: o_resp.branch_taken =  w_p[e8a_pkg::FL_Z];
            default: ;                                  // NOP and unused codes
        endcase
    end

endmodule

[sv/eight_bit_alu_status_unit.sv]
// Top level of the 8-bit ALU and status unit: input register, execution, result register.
//
// Usage:
//   Slave side (i_s_*): one word per operation. tuser carries the opcode and
//   the accumulator-mode flag, tdata the memory operand (or pulled stack byte).
//   Master side (o_m_*): one result word per operation with the write-back
//   byte and enable, the branch decision and A, X, Y, SP and P afterward.
//   An accepted word is loaded into the input register; once the result slot
//   is free or draining, the result register loads through the single-pass
//   execution logic.
//   Throughput: 1 word per cycle while i_m_tready is high. The architectural
//   registers update in the same cycle the result register loads, so a word
//   can follow its predecessor directly and sees its register updates.
//   Reset (i_rst_n low, synchronous): A, X, Y, SP, P cleared to zero and
//   both pipeline slots emptied.
//   Stall: when i_m_tready is low the result word holds; the input register
//   can still take one more word, after which o_s_tready drops until the
//   result is taken.
module eight_bit_alu_status_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [e8a_pkg::BYTE_W-1:0]     i_s_tdata,  // [7:0] operand
    input  logic [e8a_pkg::S_USER_W-1:0]   i_s_tuser,  // [5:0] req_type, [6] on_accumulator
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] result_byte, [8] write_back, [9] branch_taken, [17:10] status_out,
    // [25:18] acc_out, [33:26] x_out, [41:34] y_out, [49:42] sp_out, [55:50] zero
    output logic [e8a_pkg::M_DATA_W-1:0]   o_m_tdata
);

`include "assert_macros.svh"

    // input register
    logic                r_in_valid;
    e8a_pkg::t_req       r_in_req;
    // architectural state
    e8a_pkg::t_regs      r_regs;
    // result register
    logic                r_out_valid;
    e8a_pkg::t_regs      r_out_regs;
    e8a_pkg::t_resp      r_out_resp;

    e8a_pkg::t_regs      n_regs;
    e8a_pkg::t_resp      n_resp;
    logic                w_s_accept;
    logic                w_fire;

    // execute when an operation is waiting and the result slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    e8a_exec u_exec (
        .i_req  (r_in_req),
        .i_regs (r_regs),
        .o_regs (n_regs),
        .o_resp (n_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_req.op      <= i_s_tuser[e8a_pkg::OP_W-1:0];
            r_in_req.on_acc  <= i_s_tuser[e8a_pkg::OP_W];
            r_in_req.operand <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (w_fire) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_regs <= n_regs;
            r_out_resp <= n_resp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {(e8a_pkg::M_DATA_W - e8a_pkg::M_USED_W){1'b0}},
        r_out_regs.sp,
        r_out_regs.y,
        r_out_regs.x,
        r_out_regs.acc,
        r_out_regs.status,
        r_out_resp.branch_taken,
        r_out_resp.write_back,
        r_out_resp.result_byte
    };

    // an executed operation always shows up in the result slot next cycle
    `E8A_ASSERT(a_fire_fills_out, i_clk, i_rst_n, w_fire |=> r_out_valid)
    // no stored byte unless it is written back
    `E8A_ASSERT_NEVER(a_idle_byte_zero, i_clk, i_rst_n,
        r_out_valid && !r_out_resp.write_back && (r_out_resp.result_byte != '0))
    // a branch test never writes memory
    `E8A_ASSERT_NEVER(a_wb_and_branch, i_clk, i_rst_n,
        r_out_valid && r_out_resp.write_back && r_out_resp.branch_taken)
    // only TXS moves the stack pointer
    `E8A_ASSERT(a_sp_only_txs, i_clk, i_rst_n,
        !(w_fire && (e8a_pkg::t_op'(r_in_req.op) == e8a_pkg::OP_TXS))
            |=> $stable(r_regs.sp))

endmodule
